@@ hdl/ngga_pkg.sv @@
`default_nettype none

package ngga_pkg;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_COUNT,
    PH_LEAD,
    PH_INT,
    PH_FRAC,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } in_t;

  typedef struct packed {
    logic               field_found;
    logic signed [31:0] altitude_milli;
  } out_t;

  localparam int          HDR_LEN = 6;
  localparam logic [7:0]  HDR_TEXT [HDR_LEN] = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
  localparam logic [7:0]  CH_NUL   = 8'h00;
  localparam logic [7:0]  CH_DOLLAR = 8'h24;
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_TAB   = 8'h09;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_COMMA = 8'h2C;
  localparam logic [7:0]  CH_PLUS  = 8'h2B;
  localparam logic [7:0]  CH_MINUS = 8'h2D;
  localparam logic [7:0]  CH_POINT = 8'h2E;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;

  localparam logic [3:0]  FIELD_RESET = 4'd9;
  localparam logic [3:0]  COMMA_MAX   = 4'd15;

  // magnitude cap of the accumulator: 2^32
  localparam logic [32:0] MAG_CAP  = 33'h1_0000_0000;
  localparam logic [32:0] NEG_CAP  = 33'h0_8000_0000;
  localparam logic [32:0] POS_CAP  = 33'h0_7FFF_FFFF;

  // a * 10 + d, saturating at MAG_CAP
  function automatic logic [32:0] mul10_add(input logic [32:0] a, input logic [3:0] d);
    logic [36:0] r;
    r = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {33'd0, d};
    return (r > {4'd0, MAG_CAP}) ? MAG_CAP : r[32:0];
  endfunction

  // 10^n for small n (at most 6)
  function automatic logic [23:0] pow10(input int n);
    logic [23:0] r;
    r = 24'd1;
    for (int i = 0; i < 6; i++) begin
      if (i < n) r = 24'(r * 24'd10);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/nmea_gga_altitude_extractor_top.sv @@
`default_nettype none

// Channel  | Ports                          | Moves
// ---------+--------------------------------+---------------------------------------
// input    | in_valid, in_ready, in_data    | one byte of a buffer, last-byte flag
// result   | out_valid, out_ready, out_data | found flag and altitude, one per buffer
// config   | cfg_valid, cfg_ready, cfg_data | field number (comma count), always ready
//
// One byte per cycle sustained while no stalled result holds back a last
// byte. A byte transfer lands in the input register, the parser state is
// updated from that register, and on a buffer's last byte a snapshot goes
// to the scaling stage (one multiply by a power of ten, then saturation)
// and on to the output register. Reset (rst_n low, synchronous) empties
// all stages and restores field number 9. A stalled result holds the stages
// behind it only when another last byte has to pass; other bytes keep flowing.

module nmea_gga_altitude_extractor_top
  import ngga_pkg::*;
#(
  parameter int FRAC_DIGITS = 3
) (
  input  wire  logic       clk,
  input  wire  logic       rst_n,
  input  wire  logic       in_valid,
  output       logic       in_ready,
  input  wire  in_t        in_data,
  output       logic       out_valid,
  input  wire  logic       out_ready,
  output       out_t       out_data,
  input  wire  logic       cfg_valid,
  output       logic       cfg_ready,
  input  wire  logic [3:0] cfg_data
);

  // fraction digit counter width, and scale factor width (10^n < 2^(4n))
  localparam int FCW = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
  localparam int SCW = 4 * FRAC_DIGITS + 1;
  localparam int PW  = 33 + SCW;
  localparam logic [FCW-1:0] FRAC_MAX = FCW'(FRAC_DIGITS);

  // configuration
  logic [3:0] field_number_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_number_r <= FIELD_RESET;
    end else if (cfg_valid) begin
      field_number_r <= cfg_data;
    end
  end

  // pipeline control
  logic s1_valid_r, fin_valid_r, out_valid_r;
  in_t  s1_data_r;
  logic out_free, fin_free, s1_go, fin_go;

  assign out_free = !out_valid_r || out_ready;
  assign fin_go   = fin_valid_r && out_free;
  assign fin_free = !fin_valid_r || out_free;
  assign s1_go    = s1_valid_r && (!s1_data_r.buffer_end || fin_free);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // parser state
  phase_t         phase_r, phase_nxt;
  logic [2:0]     hdr_pos_r, hdr_pos_nxt;
  logic [3:0]     comma_r, comma_nxt;
  logic [32:0]    accum_r, accum_nxt;
  logic [FCW-1:0] frac_r, frac_nxt;
  logic           neg_r, neg_nxt;
  logic           hit_r, hit_nxt;

  logic [7:0]  c;
  logic        c_digit, c_space, c_hdr, c_comma_hit;
  logic [3:0]  comma_inc;
  logic [32:0] accum_digit;

  assign c           = s1_data_r.rx_byte;
  assign c_digit     = (c >= CH_ZERO) && (c <= CH_NINE);
  assign c_space     = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign c_hdr       = (c == HDR_TEXT[hdr_pos_r]);
  assign comma_inc   = (comma_r < COMMA_MAX) ? comma_r + 4'd1 : comma_r;
  assign c_comma_hit = (field_number_r != 4'd0) && (comma_inc == field_number_r);
  assign accum_digit = mul10_add(accum_r, c[3:0]);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (c == CH_NUL) begin
      phase_nxt = PH_DONE;
    end else begin
      case (phase_r)
        PH_HUNT: begin
          if (c_hdr && (hdr_pos_r == 3'(HDR_LEN - 1))) phase_nxt = PH_COUNT;
        end
        PH_COUNT: begin
          if ((c == CH_CR) || (c == CH_LF)) phase_nxt = PH_DONE;
          else if ((c == CH_COMMA) && c_comma_hit) phase_nxt = PH_LEAD;
        end
        PH_LEAD: begin
          if (c_space) phase_nxt = PH_LEAD;
          else if ((c == CH_PLUS) || (c == CH_MINUS) || c_digit) phase_nxt = PH_INT;
          else if (c == CH_POINT) phase_nxt = PH_FRAC;
          else phase_nxt = PH_DONE;
        end
        PH_INT: begin
          if (c_digit) phase_nxt = PH_INT;
          else if (c == CH_POINT) phase_nxt = PH_FRAC;
          else phase_nxt = PH_DONE;
        end
        PH_FRAC: begin
          if (!c_digit) phase_nxt = PH_DONE;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // datapath updates
  always_comb begin
    hdr_pos_nxt = hdr_pos_r;
    comma_nxt   = comma_r;
    accum_nxt   = accum_r;
    frac_nxt    = frac_r;
    neg_nxt     = neg_r;
    hit_nxt     = hit_r;
    if (c != CH_NUL) begin
      case (phase_r)
        PH_HUNT: begin
          if (c_hdr) begin
            hdr_pos_nxt = (hdr_pos_r == 3'(HDR_LEN - 1)) ? 3'd0 : hdr_pos_r + 3'd1;
          end else begin
            hdr_pos_nxt = (c == CH_DOLLAR) ? 3'd1 : 3'd0;
          end
        end
        PH_COUNT: begin
          if ((c == CH_COMMA) && (c != CH_CR)) begin
            comma_nxt = comma_inc;
            if (c_comma_hit) hit_nxt = 1'b1;
          end
        end
        PH_LEAD: begin
          if (!c_space) begin
            if ((c == CH_PLUS) || (c == CH_MINUS)) neg_nxt = (c == CH_MINUS);
            else if (c_digit) accum_nxt = accum_digit;
          end
        end
        PH_INT: begin
          if (c_digit) accum_nxt = accum_digit;
        end
        PH_FRAC: begin
          if (c_digit && (frac_r < FRAC_MAX)) begin
            accum_nxt = accum_digit;
            frac_nxt  = frac_r + FCW'(1);
          end
        end
        default: hdr_pos_nxt = hdr_pos_r;
      endcase
    end
  end

  // state clears after each buffer's last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      hdr_pos_r <= 3'd0;
      comma_r   <= 4'd0;
      accum_r   <= 33'd0;
      frac_r    <= '0;
      neg_r     <= 1'b0;
      hit_r     <= 1'b0;
    end else if (s1_go) begin
      if (s1_data_r.buffer_end) begin
        phase_r   <= PH_HUNT;
        hdr_pos_r <= 3'd0;
        comma_r   <= 4'd0;
        accum_r   <= 33'd0;
        frac_r    <= '0;
        neg_r     <= 1'b0;
        hit_r     <= 1'b0;
      end else begin
        phase_r   <= phase_nxt;
        hdr_pos_r <= hdr_pos_nxt;
        comma_r   <= comma_nxt;
        accum_r   <= accum_nxt;
        frac_r    <= frac_nxt;
        neg_r     <= neg_nxt;
        hit_r     <= hit_nxt;
      end
    end
  end

  // scaling stage: missing fraction digits become a power-of-ten factor
  logic           fin_hit_r, fin_neg_r;
  logic [32:0]    fin_mag_r;
  logic [FCW-1:0] fin_pad_r;
  logic           s1_to_fin;

  assign s1_to_fin = s1_go && s1_data_r.buffer_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fin_free) begin
      fin_valid_r <= s1_to_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_to_fin && fin_free) begin
      fin_hit_r <= hit_nxt;
      fin_neg_r <= neg_nxt;
      fin_mag_r <= accum_nxt;
      fin_pad_r <= FRAC_MAX - frac_nxt;
    end
  end

  logic [23:0]    pow_w;
  logic [SCW-1:0] scale;
  logic [PW-1:0]  prod;
  logic [32:0]    mag_sat, mag_neg, mag_pos;
  logic [31:0]    value;

  // saturating after each x10 equals saturating the whole product once
  assign pow_w   = pow10(int'(fin_pad_r));
  assign scale   = SCW'(pow_w);
  assign prod    = PW'(fin_mag_r) * PW'(scale);
  assign mag_sat = (prod > PW'(MAG_CAP)) ? MAG_CAP : prod[32:0];
  assign mag_neg = (mag_sat > NEG_CAP) ? NEG_CAP : mag_sat;
  assign mag_pos = (mag_sat > POS_CAP) ? POS_CAP : mag_sat;

  always_comb begin
    if (!fin_hit_r) value = 32'd0;
    else if (fin_neg_r) value = 32'(33'd0 - mag_neg);
    else value = mag_pos[31:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data.field_found    <= fin_hit_r;
      out_data.altitude_milli <= signed'(value);
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
